// ===== rtl/core/aging_avoid_list_table_assert.svh =====
// Assertion macros used by the aging avoid list table datapath.
`ifndef AGING_AVOID_LIST_TABLE_ASSERT_SVH
`define AGING_AVOID_LIST_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define AALT_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("aalt: invariant violated");
`define AALT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("aalt: sequence violated");
`else
`define AALT_ASSERT(lbl, clk_s, rst_s, prop)
`define AALT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ===== rtl/core/aalt_pkg.sv =====
// Package: constants, word types and helpers of the aging avoid list table.
package aalt_pkg;

    localparam int SLOTS    = 8;
    localparam int SHARDS   = 8;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SHARD_W  = (SHARDS > 1) ? $clog2(SHARDS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int DEPTH    = SHARDS * SLOTS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SEG_W    = 27;
    localparam int EPOCH_W  = 32;
    localparam int TTL_W    = 16;
    localparam int OCNT_W   = 4;
    localparam logic [TTL_W-1:0] TTL_RESET = 16'd16;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_EXPIRE = 2'd2,
        KIND_REMOVE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [2:0]         shard_index;
        logic [SEG_W-1:0]   segment_number;
        logic [EPOCH_W-1:0] epoch_now;
    } in_word_t;

    typedef struct packed {
        logic              hit;
        logic              evicted;
        logic [SEG_W-1:0]  evicted_segment;
        logic [OCNT_W-1:0] dropped_count;
        logic [OCNT_W-1:0] entries_used;
    } out_word_t;

    typedef struct packed {
        logic [SEG_W-1:0]   segment;
        logic [EPOCH_W-1:0] epoch;
    } entry_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic eval;
        logic append;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic do_append;
    } dp_sts_t;

    // ring position base + off, both below SLOTS
    function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W-1:0] base,
                                                    input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(SLOTS))
        begin
            sum = sum - SUM_W'(SLOTS);
        end
        return SLOT_W'(sum);
    endfunction

    function automatic logic [ADDR_W-1:0] mk_addr(input logic [SHARD_W-1:0] sh,
                                                  input logic [SLOT_W-1:0]  slot);
        return ADDR_W'(int'(sh) * SLOTS + int'(slot));
    endfunction

endpackage

// ===== rtl/core/aalt_ctrl.sv =====
// Sequencer of the aging avoid list table: handshakes and scan steps.
module aalt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  aalt_pkg::dp_sts_t sts,
    output aalt_pkg::ctl_cmd_t cmd
);
    import aalt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_APPEND,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.do_append ? ST_APPEND : ST_FINISH;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_READ;
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = !out_valid_reg || out_ready;
                if (cmd.finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/aalt_dpath.sv =====
// Datapath of the aging avoid list table: entry memory, ring heads, lengths, result word.
`include "aging_avoid_list_table_assert.svh"

module aalt_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  aalt_pkg::in_word_t          in_data,
    input  logic                        cfg_wr_en,
    input  logic [aalt_pkg::TTL_W-1:0]  cfg_wr_data,
    input  aalt_pkg::ctl_cmd_t          cmd,
    output aalt_pkg::dp_sts_t           sts,
    output aalt_pkg::out_word_t         out_data
);
    import aalt_pkg::*;

    entry_t             mem [DEPTH];
    entry_t             rd_data_reg;
    in_word_t           op_reg;
    out_word_t          out_reg;
    logic [SEG_W-1:0]   ev_seg_reg;
    logic [TTL_W-1:0]   ttl_reg;
    logic [CNT_W-1:0]   len_reg  [SHARDS];
    logic [SLOT_W-1:0]  head_reg [SHARDS];
    logic [CNT_W-1:0]   n_reg, idx_reg, w_reg;
    logic               hit_reg, ev_reg, app_reg, in_range_reg;

    logic [SHARD_W-1:0] sh_idx, in_sh_idx;
    logic [SLOT_W-1:0]  head;
    logic               in_range_in;
    logic               full;
    logic               match;
    logic [EPOCH_W-1:0] age;
    logic               keep;
    logic               compacting;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    entry_t             wr_data;
    logic [CNT_W-1:0]   res_len;
    out_word_t          out_next;

    assign in_sh_idx   = SHARD_W'(in_data.shard_index);
    assign in_range_in = 32'(in_data.shard_index) < 32'(SHARDS);
    assign sh_idx      = SHARD_W'(op_reg.shard_index);
    assign head        = head_reg[sh_idx];
    assign full        = (n_reg == CNT_W'(SLOTS));
    assign match       = (rd_data_reg.segment == op_reg.segment_number);
    assign age         = op_reg.epoch_now - rd_data_reg.epoch;
    assign compacting  = op_reg.kind inside {KIND_EXPIRE, KIND_REMOVE};

    always_comb
    begin
        case (op_reg.kind)
            KIND_EXPIRE: keep = (age < EPOCH_W'(ttl_reg));
            KIND_REMOVE: keep = !match;
            default:     keep = 1'b1;
        endcase
    end

    assign rd_addr = mk_addr(sh_idx, slot_wrap(head, idx_reg));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = mk_addr(sh_idx, slot_wrap(head, w_reg));
        wr_data = rd_data_reg;
        if (cmd.eval && compacting && keep)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.append)
        begin
            wr_en   = 1'b1;
            wr_addr = mk_addr(sh_idx, slot_wrap(head, full ? '0 : n_reg));
            wr_data = '{segment: op_reg.segment_number, epoch: op_reg.epoch_now};
        end
    end

    always_comb
    begin
        if (compacting)
        begin
            res_len = w_reg;
        end
        else if (app_reg && !full)
        begin
            res_len = n_reg + CNT_W'(1);
        end
        else
        begin
            res_len = n_reg;
        end
        out_next.hit             = hit_reg;
        out_next.evicted         = ev_reg;
        out_next.evicted_segment = ev_reg ? ev_seg_reg : '0;
        out_next.dropped_count   = compacting ? OCNT_W'(n_reg - w_reg) : '0;
        out_next.entries_used    = OCNT_W'(res_len);
    end

    assign sts.scan_done = (idx_reg == n_reg);
    assign sts.do_append = (op_reg.kind == KIND_ADD) && !hit_reg && in_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg      <= TTL_RESET;
            n_reg        <= '0;
            idx_reg      <= '0;
            w_reg        <= '0;
            hit_reg      <= 1'b0;
            ev_reg       <= 1'b0;
            app_reg      <= 1'b0;
            in_range_reg <= 1'b0;
            for (int s = 0; s < SHARDS; s++)
            begin
                len_reg[s]  <= '0;
                head_reg[s] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ttl_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                n_reg        <= in_range_in ? len_reg[in_sh_idx] : '0;
                idx_reg      <= '0;
                w_reg        <= '0;
                hit_reg      <= 1'b0;
                ev_reg       <= 1'b0;
                app_reg      <= 1'b0;
                in_range_reg <= in_range_in;
            end
            if (cmd.eval)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
                if (match && (op_reg.kind != KIND_EXPIRE))
                begin
                    hit_reg <= 1'b1;
                end
                if (compacting && keep)
                begin
                    w_reg <= w_reg + CNT_W'(1);
                end
            end
            if (cmd.append)
            begin
                app_reg <= 1'b1;
                if (full)
                begin
                    ev_reg           <= 1'b1;
                    head_reg[sh_idx] <= slot_wrap(head, CNT_W'(1));
                end
            end
            if (cmd.finish && in_range_reg)
            begin
                len_reg[sh_idx] <= res_len;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.eval && (idx_reg == '0))
        begin
            ev_seg_reg <= rd_data_reg.segment;
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    `AALT_ASSERT(a_w_le_idx, clk, rst_n, w_reg <= idx_reg)
    `AALT_ASSERT(a_idx_le_n, clk, rst_n, (idx_reg <= n_reg) && (n_reg <= CNT_W'(SLOTS)))
    `AALT_ASSERT_NEXT(a_eval_step, clk, rst_n, cmd.eval, idx_reg == $past(idx_reg) + CNT_W'(1))

endmodule

// ===== rtl/core/aging_avoid_list_table.sv =====
// Top level of the aging avoid list table.
// Keeps one ordered avoid list of up to SLOTS entries per shard, held as a ring
// in a single entry memory. Input words (kind, shard_index, segment_number,
// epoch_now) arrive on in_valid/in_ready; each gives exactly one result word on
// out_valid/out_ready. ttl_epochs is written through cfg_wr_en/cfg_wr_data.
// One word is worked at a time: the sequencer scans the addressed list one
// entry after another, each with a memory read, then compare and in-place compaction.
// An add that appends then writes its entry in an append step; once the result
// is loaded, the sequencer returns to idle and takes the next word.
// The result sits in an output register: a stalled receiver does not stop the
// next word from being accepted and scanned, only its result from being loaded.
// Reset empties every list and sets ttl_epochs to 16; the entry memory is not
// cleared, since entries at or above a list's length are never read.
module aging_avoid_list_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  aalt_pkg::in_word_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output aalt_pkg::out_word_t         out_data,
    input  logic                        cfg_wr_en,
    input  logic [aalt_pkg::TTL_W-1:0]  cfg_wr_data
);
    import aalt_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    aalt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    aalt_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_data    (out_data)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the aging avoid list table: random and directed words checked against a list model.
`timescale 1ns / 1ps

module testbench;
    import aalt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 200;
    localparam int POOL_SIZE    = 10;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    in_word_t            in_data     = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    out_word_t           out_data;
    logic                cfg_wr_en   = 1'b0;
    logic [TTL_W-1:0]    cfg_wr_data = '0;

    // model of the lists and of the ttl register
    logic [SEG_W-1:0]    listed_seg   [SHARDS][SLOTS];
    logic [EPOCH_W-1:0]  listed_epoch [SHARDS][SLOTS];
    int                  listed_len   [SHARDS] = '{default: 0};
    logic [TTL_W-1:0]    ttl_limit = TTL_RESET;

    in_word_t            word_backlog[$];
    out_word_t           results_due[$];
    out_word_t           due_word;

    int                  send_idle_pct = 38;
    int                  recv_idle_pct = 63;
    logic                hold_req      = 1'b0;
    int                  hold_left     = 0;
    int                  fail_count    = 0;
    int                  words_sent    = 0;
    int                  results_seen  = 0;
    int                  hits_seen     = 0;
    int                  evictions     = 0;
    int                  drops_seen    = 0;
    int                  cycle_count   = 0;
    logic [EPOCH_W-1:0]  epoch_clock   = 32'hFFFF_FF00;

    logic [SEG_W-1:0]    seg_pool [POOL_SIZE] = '{
        27'h0000000, 27'h7FFFFFF, 27'h0000001, 27'h0000002, 27'h0000003,
        27'h4000000, 27'h2AAAAAA, 27'h5555555, 27'h1234567, 27'h0ABCDEF
    };

    aging_avoid_list_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic out_word_t avoid_list_apply(input in_word_t w);
        out_word_t          r;
        int                 sh;
        int                 n;
        int                 kept;
        logic               present;
        logic [EPOCH_W-1:0] age;
        r = '0;
        sh = int'(w.shard_index);
        n = listed_len[sh];
        present = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (listed_seg[sh][i] == w.segment_number)
                present = 1'b1;
        end
        case (w.kind)
            KIND_LOOKUP:
                r.hit = present;
            KIND_ADD:
            begin
                r.hit = present;
                if (!present)
                begin
                    if (n >= SLOTS)
                    begin
                        r.evicted = 1'b1;
                        r.evicted_segment = listed_seg[sh][0];
                        for (int i = 0; i + 1 < SLOTS; i++)
                        begin
                            listed_seg[sh][i]   = listed_seg[sh][i + 1];
                            listed_epoch[sh][i] = listed_epoch[sh][i + 1];
                        end
                        n = SLOTS - 1;
                    end
                    listed_seg[sh][n]   = w.segment_number;
                    listed_epoch[sh][n] = w.epoch_now;
                    n++;
                end
            end
            KIND_EXPIRE:
            begin
                kept = 0;
                for (int i = 0; i < n; i++)
                begin
                    age = w.epoch_now - listed_epoch[sh][i];
                    if (age < EPOCH_W'(ttl_limit))
                    begin
                        listed_seg[sh][kept]   = listed_seg[sh][i];
                        listed_epoch[sh][kept] = listed_epoch[sh][i];
                        kept++;
                    end
                end
                r.dropped_count = OCNT_W'(n - kept);
                n = kept;
            end
            default:
            begin
                r.hit = present;
                kept = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (listed_seg[sh][i] != w.segment_number)
                    begin
                        listed_seg[sh][kept]   = listed_seg[sh][i];
                        listed_epoch[sh][kept] = listed_epoch[sh][i];
                        kept++;
                    end
                end
                r.dropped_count = OCNT_W'(n - kept);
                n = kept;
            end
        endcase
        listed_len[sh] = n;
        r.entries_used = OCNT_W'(n);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic queue_word(input kind_t k, input int sh, input logic [SEG_W-1:0] seg,
                              input logic [EPOCH_W-1:0] ep);
        in_word_t w;
        w.kind           = k;
        w.shard_index    = 3'(sh);
        w.segment_number = seg;
        w.epoch_now      = ep;
        word_backlog.push_back(w);
    endtask

    task automatic queue_random_words(input int count);
        in_word_t w;
        int       pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                w.kind = KIND_LOOKUP;
            else if (pick < 65)
                w.kind = KIND_ADD;
            else if (pick < 82)
                w.kind = KIND_EXPIRE;
            else
                w.kind = KIND_REMOVE;
            w.shard_index = 3'($urandom_range(SHARDS - 1));
            if ($urandom_range(4) == 0)
                w.segment_number = SEG_W'($urandom);
            else
                w.segment_number = seg_pool[$urandom_range(POOL_SIZE - 1)];
            pick = $urandom_range(99);
            if (pick < 4)
                epoch_clock = $urandom;
            else if (pick < 25)
                epoch_clock = epoch_clock + $urandom_range(int'(ttl_limit));
            else
                epoch_clock = epoch_clock + $urandom_range(3);
            w.epoch_now = epoch_clock;
            word_backlog.push_back(w);
        end
    endtask

    task automatic wait_drained;
        do
            @(negedge clk);
        while (word_backlog.size() != 0 || in_valid || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_ttl(input logic [TTL_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        ttl_limit = v;
    endtask

    // driver: offers words from the backlog, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                results_due.push_back(avoid_list_apply(in_data));
                words_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= word_backlog.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks results and drives out_ready, with a long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (results_due.size() == 0)
                    report_mismatch("result with nothing due", 32'(out_data.entries_used), 0);
                else
                begin
                    due_word = results_due.pop_front();
                    if (out_data.hit !== due_word.hit)
                        report_mismatch("hit", 32'(out_data.hit), 32'(due_word.hit));
                    if (out_data.evicted !== due_word.evicted)
                        report_mismatch("evicted", 32'(out_data.evicted),
                                        32'(due_word.evicted));
                    if (out_data.evicted_segment !== due_word.evicted_segment)
                        report_mismatch("evicted_segment", 32'(out_data.evicted_segment),
                                        32'(due_word.evicted_segment));
                    if (out_data.dropped_count !== due_word.dropped_count)
                        report_mismatch("dropped_count", 32'(out_data.dropped_count),
                                        32'(due_word.dropped_count));
                    if (out_data.entries_used !== due_word.entries_used)
                        report_mismatch("entries_used", 32'(out_data.entries_used),
                                        32'(due_word.entries_used));
                end
                hits_seen  += int'(out_data.hit);
                evictions  += int'(out_data.evicted);
                drops_seen += int'(out_data.dropped_count);
            end
            if (hold_req)
                hold_left = LONG_HOLD;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list, extreme segments, duplicate add, overflow, wrapped ages
        queue_word(KIND_LOOKUP, 0, 27'h0000000, 32'h0);
        queue_word(KIND_ADD,    0, 27'h7FFFFFF, 32'hFFFF_FFF0);
        queue_word(KIND_ADD,    0, 27'h0000000, 32'hFFFF_FFF8);
        queue_word(KIND_ADD,    0, 27'h7FFFFFF, 32'hFFFF_FFF9);
        queue_word(KIND_LOOKUP, 0, 27'h7FFFFFF, 32'h0);
        for (int i = 1; i <= 9; i++)
            queue_word(KIND_ADD, 7, SEG_W'(i), EPOCH_W'(99 + i));
        queue_word(KIND_EXPIRE, 0, 27'h7FFFFFF, 32'h0000_0005);
        queue_word(KIND_REMOVE, 7, 27'h0000005, 32'h0);
        queue_word(KIND_REMOVE, 7, 27'h0000005, 32'h0);
        queue_word(KIND_EXPIRE, 3, 27'h0000000, 32'hFFFF_FFFF);
        queue_word(KIND_REMOVE, 2, 27'h7FFFFFF, 32'h0);
        queue_word(KIND_LOOKUP, 7, 27'h0000001, 32'h0);
        queue_word(KIND_EXPIRE, 7, 27'h0000000, 32'd1000);
        wait_drained();

        // ttl of one epoch; receiver held off for a long stretch at the start
        write_ttl(16'd1);
        @(negedge clk);
        queue_random_words(150);
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        wait_drained();

        send_idle_pct = 63;
        recv_idle_pct = 38;
        write_ttl(16'hFFFF);
        @(negedge clk);
        queue_random_words(150);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_ttl(16'd40);
        @(negedge clk);
        queue_random_words(150);
        wait_drained();

        $display("%0d words over four ttl settings and three idling patterns, %0d results",
                 words_sent, results_seen);
        $display("hit reported %0d times, %0d evictions, %0d entries dropped",
                 hits_seen, evictions, drops_seen);
        if (fail_count == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
